// ===== rtl/sccol_pkg.sv =====
// Shared constants for the sphere-capsule collision test.
package sccol_pkg;

	localparam int AXES = 3;
	localparam int END_W = 2;
	localparam int DIST_W = 32;

	localparam logic [END_W-1:0] END_WITHIN = 2'd0;
	localparam logic [END_W-1:0] END_POS = 2'd1;
	localparam logic [END_W-1:0] END_NEG = 2'd2;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

endpackage

// ===== rtl/sccol_in_if.sv =====
// Request channel: one sphere and one capsule per transfer.
interface sccol_in_if #(
	parameter int COORD_BITS = 16,
	parameter int AXIS_FRAC_BITS = 14
) ();
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] sphere_x;
	logic signed [COORD_BITS-1:0] sphere_y;
	logic signed [COORD_BITS-1:0] sphere_z;
	logic [COORD_BITS-5:0] sphere_radius;
	logic signed [COORD_BITS-1:0] capsule_x;
	logic signed [COORD_BITS-1:0] capsule_y;
	logic signed [COORD_BITS-1:0] capsule_z;
	logic signed [AXIS_FRAC_BITS+1:0] axis_x;
	logic signed [AXIS_FRAC_BITS+1:0] axis_y;
	logic signed [AXIS_FRAC_BITS+1:0] axis_z;
	logic [COORD_BITS-4:0] capsule_length;
	logic [COORD_BITS-5:0] capsule_radius;

	modport source (
		output valid, sphere_x, sphere_y, sphere_z, sphere_radius,
		output capsule_x, capsule_y, capsule_z, axis_x, axis_y, axis_z,
		output capsule_length, capsule_radius,
		input ready
	);
	modport sink (
		input valid, sphere_x, sphere_y, sphere_z, sphere_radius,
		input capsule_x, capsule_y, capsule_z, axis_x, axis_y, axis_z,
		input capsule_length, capsule_radius,
		output ready
	);
endinterface

// ===== rtl/sccol_out_if.sv =====
// Response channel: hit flag, nearest axis point, end code and squared distance.
interface sccol_out_if #(
	parameter int COORD_BITS = 16
) ();
	logic valid;
	logic ready;
	logic hit;
	logic signed [COORD_BITS-1:0] near_x;
	logic signed [COORD_BITS-1:0] near_y;
	logic signed [COORD_BITS-1:0] near_z;
	logic [sccol_pkg::END_W-1:0] end_code;
	logic [sccol_pkg::DIST_W-1:0] distance_sq;

	modport source (
		output valid, hit, near_x, near_y, near_z, end_code, distance_sq,
		input ready
	);
	modport sink (
		input valid, hit, near_x, near_y, near_z, end_code, distance_sq,
		output ready
	);
endinterface

// ===== rtl/sphere_capsule_collision_test.sv =====
// Top level: pipelined sphere-capsule intersection test, one pair per cycle.
//
// Usage: a request transfer on req carries one sphere (center, radius) and one
// capsule (center, unit axis in Q1.AXIS_FRAC_BITS, full length, radius). A capsule
// of length zero is a plain sphere. Each request yields exactly one response on
// rsp: the hit flag, the nearest point on the capsule axis segment, an end code
// and the squared distance from the sphere center to that point, saturated to
// 32 bits.
// Pipeline: twelve register stages lie between the request transfer and
// rsp.valid (difference, projection products, projection sum, clamp,
// clamp-times-axis partial products, their sum, rounding, saturation, error,
// square, distance sum, compare).
// Throughput: one request per cycle while rsp.ready is high.
// Stalls: each stage holds its item while the stage after it is full and
// blocked, so a stalled receiver fills the empty stages first; req.ready falls
// only when every stage holds an item. Nothing is dropped or repeated.
// Reset: arst_n clears all stage valid bits at once; the block is ready for a
// request in the first cycle after reset is released.
module sphere_capsule_collision_test #(
	parameter int COORD_BITS = 16,
	parameter int AXIS_FRAC_BITS = 14
) (
	input logic clk,
	input logic arst_n,
	sccol_in_if.sink req,
	sccol_out_if.source rsp
);

	localparam int AXES = sccol_pkg::AXES;
	localparam int NSTG = 12;
	localparam int CB = COORD_BITS;
	localparam int AF = AXIS_FRAC_BITS;
	localparam int RAD_W = CB - 4;
	localparam int LEN_W = CB - 3;
	localparam int AX_W = AF + 2;
	localparam int D_W = CB + 1;
	localparam int P_W = D_W + AX_W;
	localparam int T_W = P_W + 2;
	localparam int HALF_W = LEN_W + AF - 1;
	localparam int TC_W = HALF_W + 1;
	localparam int LO_W = TC_W / 2;
	localparam int HI_W = TC_W - LO_W;
	localparam int PLO_W = LO_W + 1 + AX_W;
	localparam int PHI_W = HI_W + AX_W;
	localparam int Q_W = TC_W + AX_W;
	localparam int SH = 2 * AF;
	localparam int R_W = Q_W + 1 - SH;
	localparam int E_W = CB + 1;
	localparam int SQ_W = 2 * CB + 1;
	localparam int DSUM_W = SQ_W + 2;
	localparam int RSUM_W = RAD_W + 1;
	localparam int RSQ_W = 2 * RSUM_W;
	localparam int HIT_W = (DSUM_W > RSQ_W) ? DSUM_W : RSQ_W;
	localparam int CMP_W = (DSUM_W > sccol_pkg::DIST_W + 1) ? DSUM_W
		: sccol_pkg::DIST_W + 1;
	localparam logic [Q_W:0] RND = (Q_W + 1)'(1) << (SH - 1);

	// Handshake: a stage advances when it is empty or the next one advances.
	logic [NSTG:1] vld_s;
	logic [NSTG:1] adv;

	always_comb begin
		adv[NSTG] = !vld_s[NSTG] || rsp.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= req.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign req.ready = adv[1];

	// Stage payload registers.
	logic signed [CB-1:0] sph_s1 [AXES], sph_s2 [AXES], sph_s3 [AXES], sph_s4 [AXES];
	logic signed [CB-1:0] sph_s5 [AXES], sph_s6 [AXES], sph_s7 [AXES], sph_s8 [AXES];
	logic signed [CB-1:0] cap_s1 [AXES], cap_s2 [AXES], cap_s3 [AXES], cap_s4 [AXES];
	logic signed [CB-1:0] cap_s5 [AXES], cap_s6 [AXES], cap_s7 [AXES];
	logic signed [AX_W-1:0] ax_s1 [AXES], ax_s2 [AXES], ax_s3 [AXES], ax_s4 [AXES];
	logic signed [D_W-1:0] dif_s1 [AXES];
	logic [LEN_W-1:0] len_s1, len_s2;
	logic [RSUM_W-1:0] rsum_s1;
	logic [RSQ_W-1:0] rsq_s2, rsq_s3, rsq_s4, rsq_s5, rsq_s6, rsq_s7, rsq_s8;
	logic [RSQ_W-1:0] rsq_s9, rsq_s10, rsq_s11;
	logic signed [P_W-1:0] prod_s2 [AXES];
	logic signed [T_W-1:0] t_s3;
	logic [HALF_W-1:0] half_s3;
	logic signed [TC_W-1:0] tc_s4;
	logic [sccol_pkg::END_W-1:0] code_s4, code_s5, code_s6, code_s7, code_s8;
	logic [sccol_pkg::END_W-1:0] code_s9, code_s10, code_s11, code_s12;
	logic signed [PLO_W-1:0] plo_s5 [AXES];
	logic signed [PHI_W-1:0] phi_s5 [AXES];
	logic signed [Q_W-1:0] q_s6 [AXES];
	logic signed [R_W-1:0] r_s7 [AXES];
	logic signed [CB-1:0] near_s8 [AXES], near_s9 [AXES], near_s10 [AXES];
	logic signed [CB-1:0] near_s11 [AXES], near_s12 [AXES];
	logic signed [E_W-1:0] err_s9 [AXES];
	logic [SQ_W-1:0] sq_s10 [AXES];
	logic [DSUM_W-1:0] dist_s11;
	logic hit_s12;
	logic [sccol_pkg::DIST_W-1:0] dsq_s12;

	// Combinational logic between stages.
	logic signed [CB-1:0] sph_in [AXES], cap_in [AXES];
	logic signed [AX_W-1:0] ax_in [AXES];
	logic signed [T_W-1:0] t_sum, half_t;
	logic signed [TC_W-1:0] half_tc;
	logic in_seg;
	logic signed [TC_W-1:0] tc_next;
	logic [sccol_pkg::END_W-1:0] code_next;
	logic [Q_W:0] rnd_sum [AXES];
	logic signed [CB:0] near_sum [AXES];
	logic signed [CB-1:0] near_sat [AXES];
	logic signed [2*E_W-1:0] sq_full [AXES];
	logic [HIT_W-1:0] hit_dist, hit_rsq;
	logic [CMP_W-1:0] dist_ext;

	always_comb begin
		sph_in[0] = req.sphere_x;
		sph_in[1] = req.sphere_y;
		sph_in[2] = req.sphere_z;
		cap_in[0] = req.capsule_x;
		cap_in[1] = req.capsule_y;
		cap_in[2] = req.capsule_z;
		ax_in[0] = req.axis_x;
		ax_in[1] = req.axis_y;
		ax_in[2] = req.axis_z;

		t_sum = T_W'(prod_s2[0]) + T_W'(prod_s2[1]) + T_W'(prod_s2[2]);

		// The clamp limit is never negative, so a zero projection is always within.
		half_tc = $signed({1'b0, half_s3});
		half_t = T_W'(half_tc);
		in_seg = (t_s3 <= half_t) && (t_s3 >= -half_t);
		if (in_seg) begin
			tc_next = t_s3[TC_W-1:0];
			code_next = sccol_pkg::END_WITHIN;
		end else if (!t_s3[T_W-1]) begin
			tc_next = half_tc;
			code_next = sccol_pkg::END_POS;
		end else begin
			tc_next = -half_tc;
			code_next = sccol_pkg::END_NEG;
		end

		for (int i = 0; i < AXES; i++) begin
			// Round half away from zero: negative values take one less than half.
			rnd_sum[i] = (Q_W + 1)'(q_s6[i]) + RND - (Q_W + 1)'(q_s6[i][Q_W-1]);
			near_sum[i] = (CB + 1)'(cap_s7[i]) + (CB + 1)'(r_s7[i]);
			if (near_sum[i][CB] != near_sum[i][CB-1]) begin
				near_sat[i] = near_sum[i][CB] ? {1'b1, {(CB - 1){1'b0}}}
					: {1'b0, {(CB - 1){1'b1}}};
			end else begin
				near_sat[i] = near_sum[i][CB-1:0];
			end
			sq_full[i] = err_s9[i] * err_s9[i];
		end

		hit_dist = HIT_W'(dist_s11);
		hit_rsq = HIT_W'(rsq_s11);
		dist_ext = CMP_W'(dist_s11);
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < AXES; i++) begin
				sph_s1[i] <= sph_in[i];
				cap_s1[i] <= cap_in[i];
				ax_s1[i] <= ax_in[i];
				dif_s1[i] <= D_W'(sph_in[i]) - D_W'(cap_in[i]);
			end
			len_s1 <= req.capsule_length;
			rsum_s1 <= RSUM_W'(req.sphere_radius) + RSUM_W'(req.capsule_radius);
		end
		if (adv[2]) begin
			for (int i = 0; i < AXES; i++) begin
				prod_s2[i] <= dif_s1[i] * ax_s1[i];
				sph_s2[i] <= sph_s1[i];
				cap_s2[i] <= cap_s1[i];
				ax_s2[i] <= ax_s1[i];
			end
			len_s2 <= len_s1;
			rsq_s2 <= rsum_s1 * rsum_s1;
		end
		if (adv[3]) begin
			t_s3 <= t_sum;
			half_s3 <= HALF_W'(len_s2) << (AF - 1);
			sph_s3 <= sph_s2;
			cap_s3 <= cap_s2;
			ax_s3 <= ax_s2;
			rsq_s3 <= rsq_s2;
		end
		if (adv[4]) begin
			tc_s4 <= tc_next;
			code_s4 <= code_next;
			sph_s4 <= sph_s3;
			cap_s4 <= cap_s3;
			ax_s4 <= ax_s3;
			rsq_s4 <= rsq_s3;
		end
		if (adv[5]) begin
			// The clamped projection is split so that each product stays narrow.
			for (int i = 0; i < AXES; i++) begin
				plo_s5[i] <= $signed({1'b0, tc_s4[LO_W-1:0]}) * ax_s4[i];
				phi_s5[i] <= $signed(tc_s4[TC_W-1:LO_W]) * ax_s4[i];
			end
			sph_s5 <= sph_s4;
			cap_s5 <= cap_s4;
			rsq_s5 <= rsq_s4;
			code_s5 <= code_s4;
		end
		if (adv[6]) begin
			for (int i = 0; i < AXES; i++) begin
				q_s6[i] <= (Q_W'(phi_s5[i]) <<< LO_W) + Q_W'(plo_s5[i]);
			end
			sph_s6 <= sph_s5;
			cap_s6 <= cap_s5;
			rsq_s6 <= rsq_s5;
			code_s6 <= code_s5;
		end
		if (adv[7]) begin
			for (int i = 0; i < AXES; i++) begin
				r_s7[i] <= $signed(rnd_sum[i][Q_W:SH]);
			end
			sph_s7 <= sph_s6;
			cap_s7 <= cap_s6;
			rsq_s7 <= rsq_s6;
			code_s7 <= code_s6;
		end
		if (adv[8]) begin
			near_s8 <= near_sat;
			sph_s8 <= sph_s7;
			rsq_s8 <= rsq_s7;
			code_s8 <= code_s7;
		end
		if (adv[9]) begin
			for (int i = 0; i < AXES; i++) begin
				err_s9[i] <= E_W'(sph_s8[i]) - E_W'(near_s8[i]);
			end
			near_s9 <= near_s8;
			rsq_s9 <= rsq_s8;
			code_s9 <= code_s8;
		end
		if (adv[10]) begin
			for (int i = 0; i < AXES; i++) begin
				sq_s10[i] <= sq_full[i][SQ_W-1:0];
			end
			near_s10 <= near_s9;
			rsq_s10 <= rsq_s9;
			code_s10 <= code_s9;
		end
		if (adv[11]) begin
			dist_s11 <= DSUM_W'(sq_s10[0]) + DSUM_W'(sq_s10[1]) + DSUM_W'(sq_s10[2]);
			near_s11 <= near_s10;
			rsq_s11 <= rsq_s10;
			code_s11 <= code_s10;
		end
		if (adv[12]) begin
			hit_s12 <= (hit_dist <= hit_rsq);
			dsq_s12 <= (dist_ext > CMP_W'(sccol_pkg::DIST_MAX)) ? sccol_pkg::DIST_MAX
				: dist_ext[sccol_pkg::DIST_W-1:0];
			near_s12 <= near_s11;
			code_s12 <= code_s11;
		end
	end

	assign rsp.valid = vld_s[NSTG];
	assign rsp.hit = hit_s12;
	assign rsp.near_x = near_s12[0];
	assign rsp.near_y = near_s12[1];
	assign rsp.near_z = near_s12[2];
	assign rsp.end_code = code_s12;
	assign rsp.distance_sq = dsq_s12;

	// A projection clamped to the positive end is never negative.
	a_pos_end_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[4] && code_s4 == sccol_pkg::END_POS) |-> !tc_s4[TC_W-1])
		else $error("positive end clamp holds a negative projection");

	// A projection clamped to the negative end is never positive.
	a_neg_end_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[4] && code_s4 == sccol_pkg::END_NEG) |-> (tc_s4[TC_W-1] || tc_s4 == '0))
		else $error("negative end clamp holds a positive projection");

	// With the receiver ready, the whole pipeline moves and takes a new request.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.ready |-> req.ready)
		else $error("request side blocked while response side is ready");

	// An item that leaves the next-to-last stage lands in the output stage.
	a_last_move: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NSTG-1] && adv[NSTG-1]) |=> vld_s[NSTG])
		else $error("item lost on its way to the output stage");

endmodule
